>>> hdl/atfb_pkg.sv
`default_nettype none

package atfb_pkg;

  // frame constants
  localparam logic [7:0] START_MARK  = 8'h7E;
  localparam logic [7:0] LEN_HIGH    = 8'h00;
  localparam logic [7:0] API_ID      = 8'h01;
  localparam logic [7:0] TX_SEQ_ID   = 8'h01;
  localparam logic [7:0] TX_OPTIONS  = 8'h00;
  localparam logic [7:0] PAIR_HEADER = 8'h02;
  localparam logic [7:0] STAT_HEADER = 8'h04;
  localparam logic [7:0] PAIR_LEN    = 8'h06;
  localparam logic [7:0] STAT_LEN    = 8'h08;
  localparam logic [7:0] SUM_BASE    = 8'hFF;

  // frame kinds
  localparam logic OP_PAIR_ACK = 1'b0;
  localparam logic OP_STATUS   = 1'b1;

  // request and byte index sizes
  localparam int unsigned MaxFrame  = 12;
  localparam int unsigned IdxW      = $clog2(MaxFrame);
  localparam int unsigned ReqDataW  = 32;

  // byte positions in the frame
  localparam logic [IdxW-1:0] IDX_START    = IdxW'(0);
  localparam logic [IdxW-1:0] IDX_LEN_HI   = IdxW'(1);
  localparam logic [IdxW-1:0] IDX_LEN_LO   = IdxW'(2);
  localparam logic [IdxW-1:0] IDX_API_ID   = IdxW'(3);
  localparam logic [IdxW-1:0] IDX_TX_SEQ   = IdxW'(4);
  localparam logic [IdxW-1:0] IDX_ADDR_HI  = IdxW'(5);
  localparam logic [IdxW-1:0] IDX_ADDR_LO  = IdxW'(6);
  localparam logic [IdxW-1:0] IDX_OPTIONS  = IdxW'(7);
  localparam logic [IdxW-1:0] IDX_HEADER   = IdxW'(8);
  localparam logic [IdxW-1:0] IDX_FUEL     = IdxW'(9);
  localparam logic [IdxW-1:0] IDX_CTRL     = IdxW'(10);
  localparam logic [IdxW-1:0] IDX_PAIR_SUM = IdxW'(9);
  localparam logic [IdxW-1:0] IDX_STAT_SUM = IdxW'(11);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_e;

endpackage

`default_nettype wire

>>> hdl/api_tx_frame_builder_unit.sv
// api transmit-request frame builder, 16-bit destination address
//
// input channel (s_axis): one transaction is one request. tuser carries the
// frame kind (0 pairing acknowledge, 1 status report), tdata carries the
// destination address, fuel byte and control byte.
// output channel (m_axis): one transaction per frame byte, tlast on the
// checksum byte. a pairing acknowledge gives 10 bytes, a status report 12.
//
// latency: the start byte is offered the cycle after the request is taken.
// throughput: one byte per cycle while the receiver is ready; the byte
// counter and the single 8-bit checksum adder, fed one byte each cycle,
// set that rate. a new request can be taken in the same cycle as the
// checksum byte leaves, so back-to-back status frames run without an idle gap.
// when the receiver stalls, the current byte and all state hold; the block
// stays busy until the last byte is taken.
// reset puts the sequencer idle with no output offered and tready high.
`default_nettype none

module api_tx_frame_builder_unit
  import atfb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // [15:0] dest_address, [23:16] fuel_status, [31:24] control_byte
  input  wire logic [ReqDataW-1:0] s_axis_tdata_i,
  // [0] operation
  input  wire logic                s_axis_tuser_i,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [7:0] frame_byte
  output      logic [7:0]          m_axis_tdata_o,
  output      logic                m_axis_tlast_o
);

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;

  // request holding registers (payload, no reset)
  logic            op_q;
  logic [15:0]     addr_q;
  logic [7:0]      fuel_q;
  logic [7:0]      ctrl_q;

  logic            s_fire;
  logic            m_fire;
  logic [IdxW-1:0] last_idx;
  logic [7:0]      cur_byte;
  logic            in_sum;

  assign last_idx = (op_q == OP_STATUS) ? IDX_STAT_SUM : IDX_PAIR_SUM;

  // byte selection for the current position
  always_comb begin
    cur_byte = 8'h00;
    unique case (idx_q)
      IDX_START:    cur_byte = START_MARK;
      IDX_LEN_HI:   cur_byte = LEN_HIGH;
      IDX_LEN_LO:   cur_byte = (op_q == OP_STATUS) ? STAT_LEN : PAIR_LEN;
      IDX_API_ID:   cur_byte = API_ID;
      IDX_TX_SEQ:   cur_byte = TX_SEQ_ID;
      IDX_ADDR_HI:  cur_byte = addr_q[15:8];
      IDX_ADDR_LO:  cur_byte = addr_q[7:0];
      IDX_OPTIONS:  cur_byte = TX_OPTIONS;
      IDX_HEADER:   cur_byte = (op_q == OP_STATUS) ? STAT_HEADER : PAIR_HEADER;
      // position 9 is the fuel byte in a status frame, the checksum otherwise
      IDX_FUEL:     cur_byte = (op_q == OP_STATUS) ? fuel_q : (SUM_BASE - sum_q);
      IDX_CTRL:     cur_byte = ctrl_q;
      IDX_STAT_SUM: cur_byte = SUM_BASE - sum_q;
      default:      cur_byte = 8'h00;
    endcase
  end

  // checksum covers api id up to the last payload byte
  assign in_sum = (idx_q >= IDX_API_ID) && (idx_q < last_idx);

  assign m_axis_tvalid_o = (state_q == ST_SEND);
  assign m_axis_tdata_o  = cur_byte;
  assign m_axis_tlast_o  = (idx_q == last_idx);
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;

  // free when idle, or when the checksum byte leaves this cycle
  assign s_axis_tready_o = (state_q == ST_IDLE) || (m_fire && m_axis_tlast_o);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // sequencer: walks the byte index, the shared adder folds each byte in
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    if (m_fire) begin
      if (m_axis_tlast_o) begin
        state_d = ST_IDLE;
      end else begin
        idx_d = idx_q + IdxW'(1);
        if (in_sum) begin
          sum_d = sum_q + cur_byte;
        end
      end
    end
    if (s_fire) begin
      state_d = ST_SEND;
      idx_d   = IDX_START;
      sum_d   = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= IDX_START;
      sum_q   <= 8'h00;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q   <= s_axis_tuser_i;
      addr_q <= s_axis_tdata_i[15:0];
      fuel_q <= s_axis_tdata_i[23:16];
      ctrl_q <= s_axis_tdata_i[31:24];
    end
  end

  // a taken request starts a frame with the start mark next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (m_axis_tvalid_o && (m_axis_tdata_o == START_MARK)))
    else $error("frame did not start after request");

  // busy mid-frame: no new request taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !(m_fire && m_axis_tlast_o)) |-> !s_axis_tready_o)
    else $error("request taken while frame in flight");

  // after the last byte with no new request the output goes quiet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast_o && !s_fire) |=> !m_axis_tvalid_o)
    else $error("output kept running past frame end");

  // byte index never runs beyond the longest frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_STAT_SUM)
    else $error("byte index out of range");

endmodule

`default_nettype wire
